// ----- hdl/least_squares_line_fit_core_assert.svh -----
// Assertion macros used by the line fit back part.
`ifndef LEAST_SQUARES_LINE_FIT_CORE_ASSERT_SVH
`define LEAST_SQUARES_LINE_FIT_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define LSF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define LSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/lsf_pkg.sv -----
`timescale 1ns / 1ps
package lsf_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int SX_W       = 16 + CNT_W;
   localparam int SY_W       = 10 + CNT_W;
   localparam int SXY_W      = 26 + CNT_W;
   localparam int SXX_W      = 32 + CNT_W;
   localparam int OUT_W      = 40;
   localparam int WIDE_W     = 128;
   localparam int DIV_W      = 128;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [9:0] LOW_CUT_RESET  = 10'd10;
   localparam logic [9:0] HIGH_CUT_RESET = 10'd1023;

   localparam logic CSR_LOW_CUT  = 1'b0;
   localparam logic CSR_HIGH_CUT = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SINGULAR = 2'd1;
   localparam logic [1:0] STATUS_DROPPED  = 2'd2;

   typedef struct packed {
      logic [15:0] voltage;
      logic [9:0]  peak_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] intercept;
      logic signed [OUT_W-1:0] slope;
      logic [10:0]             points_used;
      logic [1:0]              fit_status;
   } rsp_type;

   // One queued beat from the front part: classified point.
   typedef struct packed {
      logic [15:0] x;
      logic [9:0]  y;
      logic        take;
      logic        last;
   } pt_type;

endpackage

// ----- hdl/lsf_front.sv -----
`timescale 1ns / 1ps
module lsf_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  lsf_pkg::req_type req_data,
   input  logic            csr_we,
   input  logic [0:0]      csr_index,
   input  logic [9:0]      csr_wdata,
   input  logic            q_full,
   output logic            busy,
   output logic            q_push,
   output lsf_pkg::pt_type q_data
);
   import lsf_pkg::*;

   logic [9:0] low_cut_ff, high_cut_ff;
   logic       win;

   // cut registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_cut_ff  <= LOW_CUT_RESET;
         high_cut_ff <= HIGH_CUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_CUT:  low_cut_ff  <= csr_wdata;
            CSR_HIGH_CUT: high_cut_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = q_full;
   assign win  = (req_data.peak_count > low_cut_ff) && (req_data.peak_count < high_cut_ff);

   // classify and forward
   assign q_push        = start && !busy;
   assign q_data.x      = req_data.voltage;
   assign q_data.y      = req_data.peak_count;
   assign q_data.take   = win;
   assign q_data.last   = req_data.last;
endmodule

// ----- hdl/lsf_queue.sv -----
`timescale 1ns / 1ps
module lsf_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  lsf_pkg::pt_type push_data,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output lsf_pkg::pt_type pop_data
);
   import lsf_pkg::*;

   pt_type mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wp_ff, rp_ff;
   logic [FIFO_AW:0]   cnt_ff;

   assign full      = (cnt_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
      end
   end
endmodule

// ----- hdl/lsf_back.sv -----
`timescale 1ns / 1ps
module lsf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  lsf_pkg::pt_type  q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   output lsf_pkg::rsp_type rsp_data
);
   import lsf_pkg::*;
   `include "least_squares_line_fit_core_assert.svh"

   typedef enum logic [3:0] {
      S_ACC, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_DIFF, S_PREP_A, S_DIV_A,
      S_PREP_B, S_DIV_B, S_OUT
   } state_type;

   state_type state_ff;
   logic [CNT_W-1:0] n_ff;
   logic [SX_W-1:0]  sx_ff;
   logic [SY_W-1:0]  sy_ff;
   logic [SXY_W-1:0] sxy_ff;
   logic [SXX_W-1:0] sxx_ff;
   logic             drop_ff;

   // product unit: 64x64 done as four 32x32 partials over cycles
   logic [63:0] ma_ff, mb_ff;
   logic [1:0]  part_ff;
   logic [WIDE_W-1:0] macc_ff;
   logic [WIDE_W-1:0] p_ff [6];
   logic [2:0] mi_ff;
   logic [31:0] pa, pb;
   logic [63:0] pp_ff;
   logic [WIDE_W-1:0] den_ff, an_ff, bn_ff;
   logic den_neg_ff, an_neg_ff, bn_neg_ff;

   // divider
   logic [DIV_W-1:0] num_ff, rem_ff, quo_ff, dsr_ff;
   logic [7:0] bit_ff;
   logic [DIV_W:0] rsh;
   logic [OUT_W-1:0] a_res_ff;
   logic [10:0] used_ff;

   logic [WIDE_W-1:0] den_sh;
   logic [OUT_W-1:0] sat;
   logic qneg;

   assign q_pop = (state_ff == S_ACC) && q_valid;
   assign pa = part_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
   assign pb = part_ff[1] ? mb_ff[63:32] : mb_ff[31:0];
   assign rsh = {rem_ff, num_ff[DIV_W-1]};
   assign den_sh = den_ff << 1;

   function automatic logic [OUT_W-1:0] sat_q(logic [DIV_W-1:0] q, logic neg);
      logic [OUT_W-1:0] r;
      if (!neg) r = (q > DIV_W'(64'h7FFFFFFFFF)) ? 40'h7FFFFFFFFF : q[OUT_W-1:0];
      else r = (q > DIV_W'(64'h8000000000)) ? 40'h8000000000 : (~q[OUT_W-1:0] + 1'b1);
      return r;
   endfunction

   assign qneg = (state_ff == S_DIV_A) ? (an_neg_ff != den_neg_ff) : (bn_neg_ff != den_neg_ff);
   assign sat  = sat_q(quo_ff, qneg);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_ACC;
         n_ff      <= '0;
         sx_ff     <= '0;
         sy_ff     <= '0;
         sxy_ff    <= '0;
         sxx_ff    <= '0;
         drop_ff   <= 1'b0;
         rsp_valid <= 1'b0;
         part_ff   <= '0;
         mi_ff     <= '0;
         bit_ff    <= '0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            S_ACC: begin
               if (q_valid) begin
                  if (q_data.take) begin
                     if (n_ff < CNT_W'(MAX_POINTS)) begin
                        n_ff   <= n_ff + 1'b1;
                        sx_ff  <= sx_ff + SX_W'(q_data.x);
                        sy_ff  <= sy_ff + SY_W'(q_data.y);
                        sxy_ff <= sxy_ff + SXY_W'(q_data.x) * SXY_W'(q_data.y);
                        sxx_ff <= sxx_ff + SXX_W'(q_data.x) * SXX_W'(q_data.x);
                     end else begin
                        drop_ff <= 1'b1;
                     end
                  end
                  if (q_data.last) begin
                     state_ff <= S_M0;
                     mi_ff    <= '0;
                     part_ff  <= '0;
                  end
               end
            end
            S_M0: begin
               // load operands for product mi
               unique case (mi_ff)
                  3'd0: begin ma_ff <= 64'(n_ff);  mb_ff <= 64'(sxx_ff); end
                  3'd1: begin ma_ff <= 64'(sx_ff); mb_ff <= 64'(sx_ff);  end
                  3'd2: begin ma_ff <= 64'(sxx_ff); mb_ff <= 64'(sy_ff); end
                  3'd3: begin ma_ff <= 64'(sx_ff); mb_ff <= 64'(sxy_ff); end
                  3'd4: begin ma_ff <= 64'(n_ff);  mb_ff <= 64'(sxy_ff); end
                  default: begin ma_ff <= 64'(sx_ff); mb_ff <= 64'(sy_ff); end
               endcase
               macc_ff  <= '0;
               part_ff  <= '0;
               state_ff <= S_M1;
            end
            S_M1: begin
               pp_ff    <= pa * pb;
               state_ff <= S_M2;
            end
            S_M2: begin
               // partial weight is 0, 32 or 64 bits
               macc_ff <= macc_ff +
                          (WIDE_W'(pp_ff) << {2'(part_ff[0]) + 2'(part_ff[1]), 5'd0});
               if (part_ff == 2'd3) state_ff <= S_M3;
               else begin
                  part_ff  <= part_ff + 1'b1;
                  state_ff <= S_M1;
               end
            end
            S_M3: begin
               p_ff[mi_ff] <= macc_ff;
               state_ff    <= (mi_ff == 3'd5) ? S_DIFF : S_M4;
            end
            S_M4: begin
               mi_ff    <= mi_ff + 1'b1;
               state_ff <= S_M5;
            end
            S_M5: state_ff <= S_M0;
            S_DIFF: begin
               den_neg_ff <= p_ff[0] < p_ff[1];
               den_ff     <= (p_ff[0] < p_ff[1]) ? p_ff[1] - p_ff[0] : p_ff[0] - p_ff[1];
               an_neg_ff  <= p_ff[2] < p_ff[3];
               an_ff      <= (p_ff[2] < p_ff[3]) ? p_ff[3] - p_ff[2] : p_ff[2] - p_ff[3];
               bn_neg_ff  <= p_ff[4] < p_ff[5];
               bn_ff      <= (p_ff[4] < p_ff[5]) ? p_ff[5] - p_ff[4] : p_ff[4] - p_ff[5];
               used_ff    <= 11'(n_ff);
               state_ff   <= S_PREP_A;
            end
            S_PREP_A: begin
               if (den_ff == '0) begin
                  rsp_data.intercept   <= '0;
                  rsp_data.slope       <= '0;
                  rsp_data.points_used <= used_ff;
                  rsp_data.fit_status  <= STATUS_SINGULAR;
                  state_ff             <= S_OUT;
               end else begin
                  num_ff   <= (an_ff << 17) + den_ff;
                  dsr_ff   <= den_sh;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  bit_ff   <= 8'(DIV_W - 1);
                  state_ff <= S_DIV_A;
               end
            end
            S_DIV_A, S_DIV_B: begin
               // one restoring step per cycle
               if (bit_ff == 8'hFF) begin
                  if (state_ff == S_DIV_A) begin
                     a_res_ff <= sat;
                     state_ff <= S_PREP_B;
                  end else begin
                     rsp_data.intercept   <= a_res_ff;
                     rsp_data.slope       <= sat;
                     rsp_data.points_used <= used_ff;
                     rsp_data.fit_status  <= drop_ff ? STATUS_DROPPED : STATUS_OK;
                     state_ff             <= S_OUT;
                  end
               end else begin
                  num_ff <= num_ff << 1;
                  bit_ff <= bit_ff - 1'b1;
                  if (rsh >= {1'b0, dsr_ff}) begin
                     rem_ff <= DIV_W'(rsh - {1'b0, dsr_ff});
                     quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
                  end else begin
                     rem_ff <= rsh[DIV_W-1:0];
                     quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
                  end
               end
            end
            S_PREP_B: begin
               num_ff   <= (bn_ff << 32) + den_ff;
               rem_ff   <= '0;
               quo_ff   <= '0;
               bit_ff   <= 8'(DIV_W - 1);
               state_ff <= S_DIV_B;
            end
            S_OUT: begin
               rsp_valid <= 1'b1;
               n_ff      <= '0;
               sx_ff     <= '0;
               sy_ff     <= '0;
               sxy_ff    <= '0;
               sxx_ff    <= '0;
               drop_ff   <= 1'b0;
               state_ff  <= S_ACC;
            end
            default: state_ff <= S_ACC;
         endcase
      end
   end

   `LSF_ASSERT_IMP(a_cnt_cap, clock, reset, 1'b1, n_ff <= CNT_W'(MAX_POINTS), "count over cap")
   `LSF_ASSERT_NEXT(a_out_clr, clock, reset, state_ff == S_OUT, rsp_valid && n_ff == '0, "no clear")
   `LSF_ASSERT_IMP(a_pop_acc, clock, reset, q_pop, state_ff == S_ACC, "pop outside accumulate")
endmodule

// ----- hdl/least_squares_line_fit_core.sv -----
`timescale 1ns / 1ps
// Least-squares line fit core.
// Points enter on req_data when start is high and busy low (one beat per cycle).
// Each point is window-checked against the cut registers and queued; the back
// part adds accepted points into running sums, one point per cycle while in
// its accumulate state. A point marked last closes set: the back part then
// forms six 128-bit products (four 32x32 partials each, shared multiplier) and
// runs two restoring divisions; a singular fit skips the divisions. While it
// works, the four-deep queue can fill and busy holds new points off.
// rsp_valid is high for one cycle with intercept, slope, points_used and
// fit_status; the receiver cannot stall, so nothing waits on it.
// csr_we/csr_index/csr_wdata write low_cut (0) and high_cut (1); the user must
// write them only while idle, which the block itself does not enforce.
// Synchronous reset restores cuts to 10 and 1023 and clears the sums and queue.
module least_squares_line_fit_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lsf_pkg::req_type req_data,
   output logic             rsp_valid,
   output lsf_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [9:0]       csr_wdata
);
   import lsf_pkg::*;

   logic   q_push, q_pop, q_full, q_ne;
   pt_type q_in, q_out;

   lsf_front u_front (
      .clock, .reset, .start, .req_data, .csr_we, .csr_index, .csr_wdata,
      .q_full, .busy, .q_push, .q_data(q_in)
   );

   lsf_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .pop(q_pop),
      .full(q_full), .not_empty(q_ne), .pop_data(q_out)
   );

   lsf_back u_back (
      .clock, .reset, .q_valid(q_ne), .q_data(q_out), .q_pop, .rsp_valid, .rsp_data
   );
endmodule
